// ===== sv/koc_pkg.sv =====
// Shared types and constants for the keyword occurrence counter.
// Used by koc_cell, koc_tally, the top level and the checker; no dependencies.
package koc_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 5;   // key length register width
  localparam int unsigned KEY_W    = 64;  // one key bytes register
  localparam int unsigned KEY_BITS = 2 * KEY_W;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned HOLD_W   = 4;
  localparam int unsigned MARK_LEN = 4;   // bytes held ahead of the colon
  localparam int unsigned CFG_W    = 2;   // register index width

  localparam logic [BYTE_W-1:0] NEWLINE  = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_B   = 8'h42;  // 'B'
  localparam logic [BYTE_W-1:0] CHAR_O   = 8'h6F;  // 'o'
  localparam logic [BYTE_W-1:0] CHAR_D   = 8'h64;  // 'd'
  localparam logic [BYTE_W-1:0] CHAR_Y   = 8'h79;  // 'y'
  localparam logic [BYTE_W-1:0] CHAR_COL = 8'h3A;  // ':'
  localparam logic [BYTE_W-1:0] UPPER_A  = 8'h41;
  localparam logic [BYTE_W-1:0] UPPER_Z  = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_OFS = 8'h20;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [CFG_W-1:0] {
    CFG_KEY_LOW  = 2'd0,
    CFG_KEY_HIGH = 2'd1,
    CFG_KEY_LEN  = 2'd2
  } cfg_idx_e;

  // Window byte handed from one cell to the next.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } link_t;

  // Per-transfer control from the top level to the tally logic.
  typedef struct packed {
    logic              advance;
    logic              hit;
    logic              last;
    logic [BYTE_W-1:0] raw;
  } tally_ctrl_t;

endpackage

// ===== sv/koc_cell.sv =====
// One window cell: holds one folded byte of the current line and checks
// the incoming byte against its aligned keyword byte. Depends on koc_pkg.
module koc_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            advance_i,
  input  logic                            clear_i,
  input  koc_pkg::link_t                  link_i,
  input  logic                            agree_i,
  input  logic [koc_pkg::KEY_BITS-1:0]    key_i,
  input  logic [koc_pkg::LEN_W-1:0]       len_i,
  output koc_pkg::link_t                  link_o,
  output logic                            agree_o
);

  localparam logic [koc_pkg::LEN_W-1:0] POS = koc_pkg::LEN_W'(IDX);

  logic                              valid_q;
  logic [koc_pkg::BYTE_W-1:0]        data_q;
  logic                              in_use;
  logic [koc_pkg::LEN_W-1:0]         key_pos;
  logic [koc_pkg::BYTE_W-1:0]        key_byte;

  // Window position IDX lines up with keyword byte len-1-IDX.
  assign in_use   = (len_i > POS);
  assign key_pos  = len_i - koc_pkg::LEN_W'(1) - POS;
  assign key_byte = key_i[{key_pos[3:0], 3'b000} +: koc_pkg::BYTE_W];
  assign agree_o  = agree_i && (!in_use || (link_i.valid && (link_i.data == key_byte)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= clear_i ? 1'b0 : link_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      data_q <= link_i.data;
    end
  end

  assign link_o.valid = valid_q;
  assign link_o.data  = data_q;

endmodule

// ===== sv/koc_tally.sv =====
// Body marker detection, match holdoff, per-line tally and running total.
// Depends on koc_pkg.
module koc_tally (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  koc_pkg::tally_ctrl_t           ctrl_i,
  input  logic [koc_pkg::LEN_W-1:0]      len_i,
  output logic [koc_pkg::CNT_W-1:0]      final_total_o
);

  logic [koc_pkg::BYTE_W-1:0] mark_q [koc_pkg::MARK_LEN];
  logic [koc_pkg::HOLD_W-1:0] hold_q, hold_d;
  logic [koc_pkg::CNT_W-1:0]  tally_q, tally_d;
  logic [koc_pkg::CNT_W-1:0]  total_q, total_d;
  logic                       body_q, body_d;
  logic                       marker_hit;
  logic                       close_line;
  logic [koc_pkg::CNT_W:0]    sum;
  logic [koc_pkg::LEN_W-1:0]  len_m1;

  assign marker_hit = (ctrl_i.raw == koc_pkg::CHAR_COL) && (mark_q[0] == koc_pkg::CHAR_Y) &&
                      (mark_q[1] == koc_pkg::CHAR_D) && (mark_q[2] == koc_pkg::CHAR_O) &&
                      (mark_q[3] == koc_pkg::CHAR_B);
  assign close_line = (ctrl_i.raw == koc_pkg::NEWLINE) || ctrl_i.last;
  assign body_d     = body_q || marker_hit;
  assign len_m1     = len_i - koc_pkg::LEN_W'(1);

  always_comb begin
    hold_d  = hold_q;
    tally_d = tally_q;
    if (hold_q != '0) begin
      hold_d = hold_q - koc_pkg::HOLD_W'(1);
    end else if (ctrl_i.hit) begin
      tally_d = (tally_q == koc_pkg::CNT_MAX) ? tally_q : tally_q + koc_pkg::CNT_W'(1);
      hold_d  = len_m1[koc_pkg::HOLD_W-1:0];
    end
    sum     = {1'b0, total_q} + {1'b0, tally_d};
    total_d = total_q;
    if (close_line && body_d) begin
      total_d = sum[koc_pkg::CNT_W] ? koc_pkg::CNT_MAX : sum[koc_pkg::CNT_W-1:0];
    end
  end

  assign final_total_o = total_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= '0;
      tally_q <= '0;
      total_q <= '0;
      body_q  <= 1'b0;
      for (int i = 0; i < koc_pkg::MARK_LEN; i++) begin
        mark_q[i] <= '0;
      end
    end else if (ctrl_i.advance) begin
      if (close_line) begin
        hold_q  <= '0;
        tally_q <= '0;
        for (int i = 0; i < koc_pkg::MARK_LEN; i++) begin
          mark_q[i] <= '0;
        end
      end else begin
        hold_q    <= hold_d;
        tally_q   <= tally_d;
        mark_q[0] <= ctrl_i.raw;
        for (int i = 1; i < koc_pkg::MARK_LEN; i++) begin
          mark_q[i] <= mark_q[i-1];
        end
      end
      if (ctrl_i.last) begin
        total_q <= '0;
        body_q  <= 1'b0;
      end else begin
        total_q <= total_d;
        body_q  <= body_d;
      end
    end
  end

endmodule

// ===== sv/keyword_occurrence_counter.sv =====
// Top level of the keyword occurrence counter: config registers, window
// cell chain, tally logic and output register. Depends on koc_pkg,
// koc_cell and koc_tally.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------
//   in      | sink      | in_valid_i/in_stall_o | text_byte_i, end_of_email_i
//   out     | source    | out_valid_o/out_stall_i | occurrence_total_o
//   cfg     | sink      | cfg_we_i              | cfg_index_i, cfg_data_i
//
// One byte transfers per cycle while input is not stalled; the compare across
// the cell row and the tally update complete in the cycle of the transfer.
// A result appears on out in the cycle after the transfer of a final byte and
// sits in the output register, so input keeps flowing unless that register
// is full and out is stalled.
// Reset clears the window valid bits, marker history, tally, total and
// config (key length comes up as 1). No clearing pass is needed.
module keyword_occurrence_counter #(
  parameter int unsigned KEY_MAX = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [koc_pkg::CFG_W-1:0]       cfg_index_i,
  input  logic [koc_pkg::KEY_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [koc_pkg::BYTE_W-1:0]      text_byte_i,
  input  logic                            end_of_email_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [koc_pkg::CNT_W-1:0]       occurrence_total_o
);

  localparam logic [koc_pkg::LEN_W-1:0] LEN_MAX = koc_pkg::LEN_W'(KEY_MAX);

  logic [koc_pkg::KEY_W-1:0]  key_low_q, key_high_q;
  logic [koc_pkg::LEN_W-1:0]  key_len_q;
  logic [koc_pkg::LEN_W-1:0]  eff_len;
  logic [koc_pkg::BYTE_W-1:0] folded;
  logic                       accept;
  logic                       close_line;
  logic                       out_valid_q;
  logic [koc_pkg::CNT_W-1:0]  out_total_q;
  logic [koc_pkg::CNT_W-1:0]  final_total;
  koc_pkg::tally_ctrl_t       tally_ctrl;

  koc_pkg::link_t link [KEY_MAX+1];
  logic           agree [KEY_MAX+1];

  // Config registers; writes to unused indexes drop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      key_len_q  <= koc_pkg::LEN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        koc_pkg::CFG_KEY_LOW:  key_low_q  <= cfg_data_i;
        koc_pkg::CFG_KEY_HIGH: key_high_q <= cfg_data_i;
        koc_pkg::CFG_KEY_LEN:  key_len_q  <= cfg_data_i[koc_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp key length into 1..KEY_MAX.
  always_comb begin
    eff_len = key_len_q;
    if (key_len_q == '0) begin
      eff_len = koc_pkg::LEN_W'(1);
    end else if (key_len_q > LEN_MAX) begin
      eff_len = LEN_MAX;
    end
  end

  // Stall input only when the held result cannot leave this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign close_line = (text_byte_i == koc_pkg::NEWLINE) || end_of_email_i;

  // Fold A-Z to lower case before the window.
  assign folded = ((text_byte_i >= koc_pkg::UPPER_A) && (text_byte_i <= koc_pkg::UPPER_Z)) ?
                  text_byte_i + koc_pkg::CASE_OFS : text_byte_i;

  // The new byte enters cell 0; each cell passes its held byte onward and
  // the agreement flag ripples down the row.
  assign link[0].valid = 1'b1;
  assign link[0].data  = folded;
  assign agree[0]      = 1'b1;

  for (genvar g = 0; g < KEY_MAX; g++) begin : g_cell
    koc_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (accept),
      .clear_i   (close_line),
      .link_i    (link[g]),
      .agree_i   (agree[g]),
      .key_i     ({key_high_q, key_low_q}),
      .len_i     (eff_len),
      .link_o    (link[g+1]),
      .agree_o   (agree[g+1])
    );
  end

  // The last cell's outgoing byte and valid feed nothing; its agreement flag is the hit.
  assign tally_ctrl.advance = accept;
  assign tally_ctrl.hit     = agree[KEY_MAX] && (link[KEY_MAX].valid || !link[KEY_MAX].valid);
  assign tally_ctrl.last    = end_of_email_i;
  assign tally_ctrl.raw     = text_byte_i;

  koc_tally u_tally (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (tally_ctrl),
    .len_i         (eff_len),
    .final_total_o (final_total)
  );

  // Output register: load on a final byte, drop after the transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && end_of_email_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && end_of_email_i) begin
      out_total_q <= final_total;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign occurrence_total_o = out_total_q;

endmodule

// ===== sv/koc_checker.sv =====
// Port-level checker for keyword_occurrence_counter, bound to the top level.
// Depends on koc_pkg.
module koc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        end_of_email_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [koc_pkg::CNT_W-1:0]   occurrence_total_o
);

  // A held, stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(occurrence_total_o))
    else $error("stalled result changed or vanished");

  // Input stalls only behind a blocked result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // A final byte yields a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && end_of_email_i |=> out_valid_o)
    else $error("final byte produced no result");

  // Any other byte yields no result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !end_of_email_i |=> !out_valid_o)
    else $error("result without a final byte");

endmodule

bind keyword_occurrence_counter koc_checker u_koc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .end_of_email_i     (end_of_email_i),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .occurrence_total_o (occurrence_total_o)
);

// ===== dv/tb_keyword_occurrence_counter.sv =====
// Self-checking testbench for keyword_occurrence_counter: a directed table, then random emails.
// A local byte-level model predicts each total.
// Depends on koc_pkg and keyword_occurrence_counter.
module tb_keyword_occurrence_counter;
  timeunit 1ns;
  timeprecision 1ps;

  // Index 3 has no register behind it; writes to it must be ignored.
  localparam logic [koc_pkg::CFG_W-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned WIN_LEN = 16;
  localparam int unsigned MIN_BYTES = 650;

  typedef enum logic [1:0] {
    ROW_TEXT,
    ROW_FINAL,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e                  kind;
    logic [koc_pkg::CFG_W-1:0]  reg_idx;
    logic [koc_pkg::KEY_W-1:0]  reg_data;
    logic [koc_pkg::BYTE_W-1:0] text;
    logic                       typed;   // total below is known by inspection
    logic [koc_pkg::CNT_W-1:0]  total;
  } row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [koc_pkg::CFG_W-1:0]    cfg_index_i = '0;
  logic [koc_pkg::KEY_W-1:0]    cfg_data_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic [koc_pkg::BYTE_W-1:0]   text_byte_i = '0;
  logic                         end_of_email_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [koc_pkg::CNT_W-1:0]    occurrence_total_o;

  keyword_occurrence_counter u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .text_byte_i        (text_byte_i),
    .end_of_email_i     (end_of_email_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .occurrence_total_o (occurrence_total_o)
  );

  always #1 clk_i = ~clk_i;

  // Model copy of the registers and the per-line / per-email counting state.
  logic [koc_pkg::KEY_W-1:0]  key_lo_q = '0;
  logic [koc_pkg::KEY_W-1:0]  key_hi_q = '0;
  logic [koc_pkg::LEN_W-1:0]  key_len_q = koc_pkg::LEN_W'(1);
  logic [koc_pkg::BYTE_W-1:0] fold_hist [WIN_LEN];           // folded bytes, newest first
  logic [koc_pkg::BYTE_W-1:0] raw_hist [koc_pkg::MARK_LEN];  // raw bytes ahead of the current one
  int unsigned                line_fill;
  logic [koc_pkg::HOLD_W-1:0] hold_cnt;
  logic [koc_pkg::CNT_W-1:0]  line_matches;
  logic [koc_pkg::CNT_W-1:0]  email_total;
  logic                       marker_found;

  logic [koc_pkg::CNT_W-1:0]  pending_totals [$];   // totals owed by the block, oldest first
  logic [koc_pkg::BYTE_W-1:0] email_q [$];

  int unsigned bytes_sent = 0;
  int unsigned emails_sent = 0;
  int unsigned settings_used = 0;
  int unsigned totals_checked = 0;
  int unsigned miscounts = 0;
  int unsigned burst_left = 0;
  int unsigned stall_tick = 0;

  // ---------------------------------------------------------------------------
  // Counting model
  // ---------------------------------------------------------------------------

  // Key length as the block uses it: 0 counts as 1, anything past 16 as 16.
  function automatic int unsigned key_span();
    if (key_len_q == 0) return 1;
    if (key_len_q > WIN_LEN) return WIN_LEN;
    return key_len_q;
  endfunction

  function automatic logic [koc_pkg::BYTE_W-1:0] key_at(input int unsigned idx);
    if (idx < 8) return key_lo_q[idx*8 +: 8];
    return key_hi_q[(idx-8)*8 +: 8];
  endfunction

  function automatic logic [koc_pkg::CNT_W-1:0] sat_add(input logic [koc_pkg::CNT_W-1:0] a,
                                                        input logic [koc_pkg::CNT_W-1:0] b);
    logic [koc_pkg::CNT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[koc_pkg::CNT_W] ? koc_pkg::CNT_MAX : sum[koc_pkg::CNT_W-1:0];
  endfunction

  function automatic void clear_line();
    foreach (fold_hist[i]) fold_hist[i] = '0;
    foreach (raw_hist[i]) raw_hist[i] = '0;
    line_fill = 0;
    hold_cnt = '0;
    line_matches = '0;
  endfunction

  function automatic void apply_reg(input logic [koc_pkg::CFG_W-1:0] idx,
                                    input logic [koc_pkg::KEY_W-1:0] data);
    case (idx)
      koc_pkg::CFG_KEY_LOW:  key_lo_q = data;
      koc_pkg::CFG_KEY_HIGH: key_hi_q = data;
      koc_pkg::CFG_KEY_LEN:  key_len_q = data[koc_pkg::LEN_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the model by one byte; returns 1 when the byte closes the email.
  function automatic bit tally_byte(input logic [koc_pkg::BYTE_W-1:0] raw, input logic last,
                                    output logic [koc_pkg::CNT_W-1:0] total);
    logic [koc_pkg::BYTE_W-1:0] folded;
    int unsigned len;
    bit hit;
    folded = raw;
    if (raw >= koc_pkg::UPPER_A && raw <= koc_pkg::UPPER_Z) folded = raw + koc_pkg::CASE_OFS;
    len = key_span();
    total = '0;

    // The marker is matched on raw bytes, case-sensitive.
    if (raw == koc_pkg::CHAR_COL && raw_hist[0] == koc_pkg::CHAR_Y &&
        raw_hist[1] == koc_pkg::CHAR_D && raw_hist[2] == koc_pkg::CHAR_O &&
        raw_hist[3] == koc_pkg::CHAR_B) marker_found = 1'b1;
    for (int i = koc_pkg::MARK_LEN - 1; i > 0; i--) raw_hist[i] = raw_hist[i-1];
    raw_hist[0] = raw;

    for (int i = WIN_LEN - 1; i > 0; i--) fold_hist[i] = fold_hist[i-1];
    fold_hist[0] = folded;
    if (line_fill < WIN_LEN) line_fill++;

    // A match blocks the next len-1 bytes, so copies never overlap.
    if (hold_cnt != 0) begin
      hold_cnt--;
    end else if (line_fill >= len) begin
      hit = 1'b1;
      for (int i = 0; i < len; i++) begin
        if (fold_hist[i] != key_at(len - 1 - i)) hit = 1'b0;
      end
      if (hit) begin
        line_matches = sat_add(line_matches, 1);
        hold_cnt = koc_pkg::HOLD_W'(len - 1);
      end
    end

    // Line end: the tally only counts once the marker has shown up.
    if (raw == koc_pkg::NEWLINE || last) begin
      if (marker_found) email_total = sat_add(email_total, line_matches);
      clear_line();
    end

    if (last) begin
      total = email_total;
      email_total = '0;
      marker_found = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Present one byte and hold it until the transfer; bursts of random
  // length separated by random gaps. Record the expected total on the
  // final byte, or the typed one where the table gives it.
  task automatic send_byte(input logic [koc_pkg::BYTE_W-1:0] raw, input logic last,
                           input logic typed, input logic [koc_pkg::CNT_W-1:0] typed_total);
    logic [koc_pkg::CNT_W-1:0] total;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      // Mostly short bursts, now and then a long stretch with no gaps.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    text_byte_i    <= raw;
    end_of_email_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
    if (tally_byte(raw, last, total)) pending_totals.push_back(typed ? typed_total : total);
  endtask

  // Drop valid and wait until every owed total has come out, then let the
  // output register settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [koc_pkg::CFG_W-1:0] idx,
                           input logic [koc_pkg::KEY_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    apply_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random case on letters, so folding is exercised.
  function automatic logic [koc_pkg::BYTE_W-1:0] mixed_case(input logic [koc_pkg::BYTE_W-1:0] b);
    if (b >= koc_pkg::UPPER_A + koc_pkg::CASE_OFS && b <= koc_pkg::UPPER_Z + koc_pkg::CASE_OFS &&
        $urandom_range(0, 1))
      return b - koc_pkg::CASE_OFS;
    return b;
  endfunction

  // Build one email: a few lines of key copies (some broken), noise and
  // odd bytes, with the marker placed in some line or missing.
  task automatic build_email();
    int unsigned n_lines;
    int unsigned marker_line;
    int unsigned n_segs;
    int unsigned marker_seg;
    int unsigned len;
    int unsigned copy_len;
    email_q.delete();
    len = key_span();
    n_lines = $urandom_range(1, 3);
    marker_line = $urandom_range(0, n_lines);   // n_lines: no marker at all
    for (int ln = 0; ln < n_lines; ln++) begin
      n_segs = $urandom_range(1, 4);
      marker_seg = $urandom_range(0, n_segs);
      for (int s = 0; s <= n_segs; s++) begin
        if (ln == marker_line && s == marker_seg) begin
          case ($urandom_range(0, 7))
            0:       email_q = {email_q, "b", "o", "d", "y", ":"};
            1:       email_q = {email_q, "B", "o", "d", "y"};
            2:       email_q = {email_q, "B", "O", "D", "Y", ":"};
            default: email_q = {email_q, koc_pkg::CHAR_B, koc_pkg::CHAR_O, koc_pkg::CHAR_D,
                                koc_pkg::CHAR_Y, koc_pkg::CHAR_COL};
          endcase
        end
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            // Whole copy of the key; one in eight loses its last byte.
            copy_len = ($urandom_range(0, 7) == 0) ? len - 1 : len;
            for (int k = 0; k < copy_len; k++) email_q.push_back(mixed_case(key_at(k)));
          end
          5, 6, 7: begin
            repeat ($urandom_range(1, 3)) begin
              case ($urandom_range(0, 4))
                0:       email_q.push_back("x");
                1:       email_q.push_back(" ");
                default: email_q.push_back(mixed_case(key_at($urandom_range(0, len - 1))));
              endcase
            end
          end
          8: email_q.push_back(8'($urandom_range(0, 255)));
          default: ;
        endcase
      end
      if (ln != n_lines - 1 || $urandom_range(0, 1)) email_q.push_back(koc_pkg::NEWLINE);
    end
    if (email_q.size() == 0) email_q.push_back("x");
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: the stall pattern rotates through four modes
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    case ((stall_tick / 97) % 4)
      0:       out_stall_i <= 1'b0;                          // free flow
      1:       out_stall_i <= ($urandom_range(0, 1) == 0);   // coin flip
      2:       out_stall_i <= ((stall_tick % 5) < 3);        // heavy, periodic
      default: out_stall_i <= ($urandom_range(0, 3) == 0);   // light
    endcase
  end

  // ---------------------------------------------------------------------------
  // Checker: compare each transferred total with the oldest owed one
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_totals.size() == 0) begin
        $display("%0t: occurrence_total expected none, got %0d", $time, occurrence_total_o);
        miscounts++;
      end else begin
        if (occurrence_total_o !== pending_totals[0]) begin
          $display("%0t: occurrence_total expected %0d, got %0d",
                   $time, pending_totals[0], occurrence_total_o);
          miscounts++;
        end
        void'(pending_totals.pop_front());
        totals_checked++;
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic row_t txt_row(input logic [koc_pkg::BYTE_W-1:0] b);
    return '{kind: ROW_TEXT, reg_idx: '0, reg_data: '0, text: b, typed: 1'b0, total: '0};
  endfunction

  function automatic row_t end_row(input logic [koc_pkg::BYTE_W-1:0] b, input logic typed,
                                   input logic [koc_pkg::CNT_W-1:0] total);
    return '{kind: ROW_FINAL, reg_idx: '0, reg_data: '0, text: b, typed: typed, total: total};
  endfunction

  function automatic row_t reg_row(input logic [koc_pkg::CFG_W-1:0] idx,
                                   input logic [koc_pkg::KEY_W-1:0] data);
    return '{kind: ROW_CFG, reg_idx: idx, reg_data: data, text: '0, typed: 1'b0, total: '0};
  endfunction

  row_t stim_table [34];

  initial begin
    logic [koc_pkg::KEY_BITS-1:0] key_bits;
    logic [koc_pkg::KEY_W-1:0]    len_data;
    logic [koc_pkg::LEN_W-1:0]    len_code;

    clear_line();
    email_total = '0;
    marker_found = 1'b0;

    stim_table = '{
      // Reset key is one zero byte; no marker, so nothing counts.
      end_row("x", 1'b1, 0),
      // Marker then a zero byte: the zero byte is an ordinary match.
      txt_row("B"), txt_row("o"), txt_row("d"), txt_row("y"), txt_row(":"),
      end_row(8'h00, 1'b1, 1),
      // Key "ab": a match ahead of the marker still counts for its line,
      // and the spare index must not disturb anything.
      reg_row(koc_pkg::CFG_KEY_LOW, 64'h6261), reg_row(koc_pkg::CFG_KEY_LEN, 64'd2),
      reg_row(CFG_SPARE, '1),
      txt_row("a"), txt_row("B"), txt_row("B"), txt_row("o"), txt_row("d"), txt_row("y"),
      end_row(":", 1'b1, 1),
      // Length 0 acts as 1; an upper-case key byte never sees folded text.
      reg_row(koc_pkg::CFG_KEY_LOW, 64'h0A41), reg_row(koc_pkg::CFG_KEY_LEN, 64'd0),
      txt_row("B"), txt_row("o"), txt_row("d"), txt_row("y"), txt_row(":"),
      end_row("A", 1'b1, 0),
      // Newline key byte: matches only the newline that ends the line.
      reg_row(koc_pkg::CFG_KEY_LOW, 64'h0A), reg_row(koc_pkg::CFG_KEY_HIGH, '1),
      txt_row("B"), txt_row("o"), txt_row("d"), txt_row("y"), txt_row(":"),
      txt_row(koc_pkg::NEWLINE),
      end_row("q", 1'b0, 0)
    };

    // Hold reset at first, then release it once for the whole run.
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[r]) begin
      case (stim_table[r].kind)
        ROW_CFG: begin
          drain();
          write_reg(stim_table[r].reg_idx, stim_table[r].reg_data);
        end
        ROW_TEXT:  send_byte(stim_table[r].text, 1'b0, 1'b0, '0);
        default: begin
          send_byte(stim_table[r].text, 1'b1, stim_table[r].typed, stim_table[r].total);
          emails_sent++;
        end
      endcase
    end

    // Random part: each pass picks a key setting, then sends a few emails.
    // Lengths cycle through the extremes (31, 16, 0, 1) and short keys.
    while (bytes_sent < MIN_BYTES) begin
      drain();
      for (int k = 0; k < 16; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: key_bits[k*8 +: 8] = 8'("a" + $urandom_range(0, 2));
          6:                key_bits[k*8 +: 8] = koc_pkg::UPPER_A;
          7:                key_bits[k*8 +: 8] = 8'h00;
          8:                key_bits[k*8 +: 8] = koc_pkg::NEWLINE;
          default:          key_bits[k*8 +: 8] = 8'($urandom_range(0, 255));
        endcase
      end
      case (settings_used % 5)
        0:       len_code = koc_pkg::LEN_W'(31);
        1:       len_code = koc_pkg::LEN_W'(16);
        2:       len_code = koc_pkg::LEN_W'(0);
        3:       len_code = koc_pkg::LEN_W'(1);
        default: len_code = koc_pkg::LEN_W'($urandom_range(2, 6));
      endcase
      // Junk in the unused upper bits of the length write.
      len_data = {$urandom, $urandom};
      len_data[koc_pkg::LEN_W-1:0] = len_code;
      write_reg(koc_pkg::CFG_KEY_LOW, key_bits[koc_pkg::KEY_W-1:0]);
      write_reg(koc_pkg::CFG_KEY_HIGH, key_bits[koc_pkg::KEY_BITS-1:koc_pkg::KEY_W]);
      write_reg(koc_pkg::CFG_KEY_LEN, len_data);
      if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, {$urandom, $urandom});
      settings_used++;

      repeat ($urandom_range(2, 4)) begin
        if (bytes_sent < MIN_BYTES) begin
          build_email();
          foreach (email_q[k]) send_byte(email_q[k], k == email_q.size() - 1, 1'b0, '0);
          emails_sent++;
        end
      end
    end

    drain();
    $display("Counted keywords in %0d emails (%0d bytes) across %0d random key settings;",
             emails_sent, bytes_sent, settings_used);
    $display("%0d totals checked under input gaps and output stalls.", totals_checked);
    if (miscounts == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
